FILE: design/ovl_pkg.sv
// Package with the shared types and codes of the overcurrent verify latch.
package ovl_pkg;

  localparam int unsigned CNT_W = 26;
  localparam int unsigned DLY_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_TIME = 2'd1;

  localparam logic [DLY_W-1:0] VERIFY_DELAY_RST  = 16'd100;
  localparam logic [CNT_W-1:0] RECOVERY_TIME_RST = 26'd100000;

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_PENDING   = 2'd1;
  localparam logic [1:0] PH_WINDOW    = 2'd2;
  localparam logic [1:0] PH_PROTECTED = 2'd3;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_PENDING   = 3'd1;
  localparam logic [2:0] EV_WINDOW    = 3'd2;
  localparam logic [2:0] EV_EXPIRED   = 3'd3;
  localparam logic [2:0] EV_CONFIRMED = 3'd4;
  localparam logic [2:0] EV_RECOVERED = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PEND = 4'b0010,
    ST_WIN  = 4'b0100,
    ST_PROT = 4'b1000
  } bst_t;

  typedef struct packed {
    logic       bridge_id;
    logic [2:0] event_res;
    logic [1:0] phase;
    logic       drive_off;
    logic       last;
  } res_t;

  function automatic logic [1:0] phase_of(input bst_t st);
    logic [1:0] ph;
    case (st)
      ST_PEND: ph = PH_PENDING;
      ST_WIN:  ph = PH_WINDOW;
      ST_PROT: ph = PH_PROTECTED;
      default: ph = PH_IDLE;
    endcase
    return ph;
  endfunction

endpackage

FILE: design/ovl_in_if.sv
// Input channel interface: event words carrying kind and bridge.
interface ovl_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic bridge;

  modport source (output valid, output kind, output bridge, input ready);
  modport sink (input valid, input kind, input bridge, output ready);
endinterface

FILE: design/ovl_out_if.sv
// Result channel interface: one bridge status word per handshake.
interface ovl_out_if;
  logic       valid;
  logic       ready;
  logic       bridge_id;
  logic [2:0] event_res;
  logic [1:0] phase;
  logic       drive_off;
  logic       last;

  modport source (output valid, output bridge_id, output event_res, output phase,
                  output drive_off, output last, input ready);
  modport sink (input valid, input bridge_id, input event_res, input phase,
                input drive_off, input last, output ready);
endinterface

FILE: design/overcurrent_verify_latch.sv
// Overcurrent verify latch top level: per-bridge fault qualification and latching.
//
// Input words arrive on in_ch: kind 0 is a timebase tick for all bridges, kind 1 is a
// comparator falling edge of the bridge named in the word. Each accepted word updates the
// bridge state at once and loads its results into a result buffer in the same cycle.
// An edge gives one result word; a tick gives BRIDGES result words, bridge 0 first,
// with last set on the final one. Results leave on out_ch one word per cycle while the
// receiver is ready, the first in the cycle after its input word is accepted.
// An edge word can be taken every cycle while the receiver is ready; a tick holds the
// single result port until all BRIDGES of its result words have left. A new word is
// taken in the cycle the final result word of the previous one leaves, so there are no
// bubbles between words. When the receiver stalls, the buffered words hold and
// in_ch.ready stays low until the final word of the current group is taken.
// Registers are written through cfg_we, cfg_index and cfg_data, by the user only while the
// block is idle, not enforced; index 0 is verify delay, 1 recovery time, others ignored.
// Synchronous reset puts every bridge in idle with a zero tick count, empties the result
// buffer and restores the register defaults of 100 and 100000 ticks.
module overcurrent_verify_latch #(
  parameter int BRIDGES = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ovl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ovl_pkg::CNT_W-1:0]     cfg_data,
  ovl_in_if.sink                        in_ch,
  ovl_out_if.source                     out_ch
);

  localparam int RDW = (BRIDGES > 1) ? $clog2(BRIDGES) : 1;

  logic [ovl_pkg::DLY_W-1:0] verify_r;
  logic [ovl_pkg::CNT_W-1:0] recovery_r;

  ovl_pkg::bst_t             st_r   [BRIDGES];
  ovl_pkg::bst_t             st_nxt [BRIDGES];
  logic [ovl_pkg::CNT_W-1:0] cnt_r  [BRIDGES];
  logic [ovl_pkg::CNT_W-1:0] cnt_nxt[BRIDGES];

  ovl_pkg::res_t res_r  [BRIDGES];
  ovl_pkg::res_t res_nxt[BRIDGES];
  ovl_pkg::res_t cur_res;

  logic           valid_r;
  logic [RDW-1:0] rd_r;
  logic           in_acc;
  logic           out_acc;
  logic           fin;

  assign cur_res = res_r[rd_r];
  assign out_acc = valid_r && out_ch.ready;
  assign fin     = out_acc && cur_res.last;
  assign in_ch.ready = !valid_r || fin;
  assign in_acc  = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = valid_r;
  assign out_ch.bridge_id = cur_res.bridge_id;
  assign out_ch.event_res = cur_res.event_res;
  assign out_ch.phase     = cur_res.phase;
  assign out_ch.drive_off = cur_res.drive_off;
  assign out_ch.last      = cur_res.last;

  always_comb begin
    logic [2:0] e_ev;
    logic [1:0] e_ph;
    e_ev = ovl_pkg::EV_NONE;
    e_ph = ovl_pkg::PH_IDLE;
    for (int i = 0; i < BRIDGES; i++) begin
      logic [ovl_pkg::CNT_W-1:0] lim;
      logic [ovl_pkg::CNT_W-1:0] inc;
      logic [2:0]                ev;
      logic                      hit;
      lim = (st_r[i] == ovl_pkg::ST_PROT) ? recovery_r : ovl_pkg::CNT_W'(verify_r);
      if (lim == '0) begin
        lim = ovl_pkg::CNT_W'(1);
      end
      inc = cnt_r[i] + ovl_pkg::CNT_W'(1);
      hit = in_ch.kind && (32'(in_ch.bridge) == i);
      st_nxt[i]  = st_r[i];
      cnt_nxt[i] = cnt_r[i];
      ev = ovl_pkg::EV_NONE;
      if (!in_ch.kind) begin
        if (st_r[i] != ovl_pkg::ST_IDLE) begin
          if (inc < lim) begin
            cnt_nxt[i] = inc;
          end else begin
            cnt_nxt[i] = '0;
            case (st_r[i])
              ovl_pkg::ST_PEND: begin
                st_nxt[i] = ovl_pkg::ST_WIN;
                ev = ovl_pkg::EV_WINDOW;
              end
              ovl_pkg::ST_WIN: begin
                st_nxt[i] = ovl_pkg::ST_IDLE;
                ev = ovl_pkg::EV_EXPIRED;
              end
              default: begin
                st_nxt[i] = ovl_pkg::ST_IDLE;
                ev = ovl_pkg::EV_RECOVERED;
              end
            endcase
          end
        end
      end else if (hit) begin
        case (st_r[i])
          ovl_pkg::ST_IDLE: begin
            st_nxt[i]  = ovl_pkg::ST_PEND;
            cnt_nxt[i] = '0;
            ev = ovl_pkg::EV_PENDING;
          end
          ovl_pkg::ST_WIN: begin
            st_nxt[i]  = ovl_pkg::ST_PROT;
            cnt_nxt[i] = '0;
            ev = ovl_pkg::EV_CONFIRMED;
          end
          default: ev = ovl_pkg::EV_NONE;
        endcase
        e_ev = ev;
        e_ph = ovl_pkg::phase_of(st_nxt[i]);
      end
      res_nxt[i].bridge_id = 1'(i);
      res_nxt[i].event_res = ev;
      res_nxt[i].phase     = ovl_pkg::phase_of(st_nxt[i]);
      res_nxt[i].drive_off = (st_nxt[i] == ovl_pkg::ST_PROT);
      res_nxt[i].last      = (i == BRIDGES - 1);
    end
    if (in_ch.kind) begin
      res_nxt[0].bridge_id = in_ch.bridge;
      res_nxt[0].event_res = e_ev;
      res_nxt[0].phase     = e_ph;
      res_nxt[0].drive_off = (e_ph == ovl_pkg::PH_PROTECTED);
      res_nxt[0].last      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verify_r   <= ovl_pkg::VERIFY_DELAY_RST;
      recovery_r <= ovl_pkg::RECOVERY_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ovl_pkg::CFG_VERIFY_DELAY:  verify_r   <= cfg_data[ovl_pkg::DLY_W-1:0];
        ovl_pkg::CFG_RECOVERY_TIME: recovery_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BRIDGES; i++) begin
        st_r[i]  <= ovl_pkg::ST_IDLE;
        cnt_r[i] <= '0;
      end
    end else if (in_acc) begin
      for (int i = 0; i < BRIDGES; i++) begin
        st_r[i]  <= st_nxt[i];
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < BRIDGES; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rd_r    <= '0;
    end else if (in_acc) begin
      valid_r <= 1'b1;
      rd_r    <= '0;
    end else if (out_acc) begin
      if (cur_res.last) begin
        valid_r <= 1'b0;
      end else begin
        rd_r <= rd_r + RDW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_load_starts_at_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (valid_r && rd_r == '0))
    else $error("result buffer not restarted after an accepted word");

  a_drive_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.drive_off == (out_ch.phase == ovl_pkg::PH_PROTECTED)))
    else $error("drive_off disagrees with reported phase");

  a_protect_from_window: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r[0] == ovl_pkg::ST_PROT) |-> ($past(st_r[0]) == ovl_pkg::ST_WIN))
    else $error("bridge latched without a verify window");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (32'(rd_r) < BRIDGES))
    else $error("result read index past the last bridge");
`endif

endmodule
